// ===== rtl/u8u16_pkg.sv =====
// shared types and constants for the utf-8 to utf-16 decoder
package u8u16_pkg;

  localparam int unsigned UnitW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [UnitW-1:0] UnitMax     = 16'hFFFF;
  localparam logic [UnitW-1:0] Replacement = 16'hFFFD;
  localparam logic [UnitW-1:0] LimitReset  = 16'hFFFF;

  // lead byte range bounds
  localparam logic [ByteW-1:0] AsciiMax  = 8'h7F;
  localparam logic [ByteW-1:0] Lead2Min  = 8'hC0;
  localparam logic [ByteW-1:0] Lead2Max  = 8'hDF;
  localparam logic [ByteW-1:0] Lead3Min  = 8'hE0;
  localparam logic [ByteW-1:0] Lead3Max  = 8'hEF;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegCountOnly = 1'd0;
  localparam logic [CfgIdxW-1:0] RegOutLimit  = 1'd1;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             in_last;
  } in_item_t;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             unit_valid;
    logic             bad_lead;
    logic [UnitW-1:0] unit_count;
    logic             truncated;
    logic             out_last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       bytes_pending;
    logic [UnitW-1:0] accumulator;
    logic [UnitW-1:0] units_done;
    logic             stopped;
  } dec_state_t;

  typedef struct packed {
    logic             count_only;
    logic [UnitW-1:0] out_limit;
  } dec_cfg_t;

endpackage

// ===== rtl/utf8_to_utf16_decoder_unit.sv =====
// utf-8 to utf-16 decoder: one byte per cycle, zero or one code unit result per byte
// latency: a result is valid in the cycle after its byte transfer
// throughput: one byte per cycle while out_ready keeps the result register drained, set by
//   the single decode step between the string state registers and the result register
// reset: rst clears the string state and out_valid, count_only to 0, out_limit to 65535
module utf8_to_utf16_decoder_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [u8u16_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [u8u16_pkg::UnitW-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  u8u16_pkg::in_item_t             in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output u8u16_pkg::out_item_t            out_item
);
  import u8u16_pkg::*;

  dec_cfg_t   cfg;
  dec_state_t state;
  dec_state_t state_next;
  logic       has_result;
  out_item_t  result;
  logic       in_fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count_only <= 1'b0;
      cfg.out_limit  <= LimitReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegCountOnly: cfg.count_only <= cfg_data[0];
        RegOutLimit:  cfg.out_limit  <= cfg_data;
        default:      ;
      endcase
    end
  end

  // decode step
  u8u16_step u_step (
    .in_item    (in_item),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .has_result (has_result),
    .result     (result)
  );

  // accept while the result register is empty or being drained
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // string state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_fire && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && has_result) begin
      out_item <= result;
    end
  end

`ifndef SYNTHESIS
  // an emitted unit never carries the truncated flag
  a_emit_not_truncated: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.unit_valid |-> !out_item.truncated)
    else $error("emitted unit marked truncated");

  // replacement flag only on an emitted 0xfffd
  a_bad_lead_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.bad_lead |->
      out_item.unit_valid && out_item.code_unit == Replacement)
    else $error("bad_lead without replacement unit");

  // count-only mode emits no units
  a_count_only_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && cfg.count_only |-> !out_item.unit_valid)
    else $error("unit emitted in count-only mode");

  // last byte of a string clears the string state
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_item.in_last |=>
      state.units_done == '0 && state.bytes_pending == 2'd0 && !state.stopped)
    else $error("string state not cleared after last byte");
`endif

endmodule

// ===== rtl/u8u16_step.sv =====
// per-byte decode step: next string state and the result for one byte
module u8u16_step (
  input  u8u16_pkg::in_item_t   in_item,
  input  u8u16_pkg::dec_state_t state,
  input  u8u16_pkg::dec_cfg_t   cfg,
  output u8u16_pkg::dec_state_t state_next,
  output logic                  has_result,
  output u8u16_pkg::out_item_t  result
);
  import u8u16_pkg::*;

  logic             have;
  logic             bad;
  logic             emit;
  logic [UnitW-1:0] unit;
  logic [UnitW-1:0] acc_new;
  logic [1:0]       pend_new;
  logic [UnitW-1:0] done_new;
  logic             stop_new;

  // byte classification and accumulation
  always_comb begin
    have     = 1'b0;
    bad      = 1'b0;
    unit     = '0;
    acc_new  = state.accumulator;
    pend_new = state.bytes_pending;
    priority if (state.bytes_pending != 2'd0) begin
      acc_new  = {state.accumulator[UnitW-7:0], in_item.in_byte[5:0]};
      pend_new = state.bytes_pending - 2'd1;
      if (pend_new == 2'd0) begin
        have = 1'b1;
        unit = acc_new;
      end
    end else if (in_item.in_byte <= AsciiMax) begin
      have = 1'b1;
      unit = {{(UnitW-ByteW){1'b0}}, in_item.in_byte};
    end else if (in_item.in_byte >= Lead2Min && in_item.in_byte <= Lead2Max) begin
      acc_new  = {{(UnitW-5){1'b0}}, in_item.in_byte[4:0]};
      pend_new = 2'd1;
    end else if (in_item.in_byte >= Lead3Min && in_item.in_byte <= Lead3Max) begin
      acc_new  = {{(UnitW-4){1'b0}}, in_item.in_byte[3:0]};
      pend_new = 2'd2;
    end else begin
      have = 1'b1;
      bad  = 1'b1;
      unit = Replacement;
    end
  end

  // unit counting against the limit
  always_comb begin
    emit     = 1'b0;
    done_new = state.units_done;
    stop_new = state.stopped;
    if (have) begin
      priority if (cfg.count_only) begin
        if (state.units_done != UnitMax) begin
          done_new = state.units_done + 16'd1;
        end
      end else if (!state.stopped && state.units_done < cfg.out_limit) begin
        done_new = state.units_done + 16'd1;
        emit     = 1'b1;
      end else begin
        stop_new = 1'b1;
      end
    end
  end

  // result and end-of-string clear
  always_comb begin
    has_result        = emit | in_item.in_last;
    result.code_unit  = emit ? unit : '0;
    result.unit_valid = emit;
    result.bad_lead   = emit & bad;
    result.unit_count = done_new;
    result.truncated  = stop_new;
    result.out_last   = in_item.in_last;
    if (in_item.in_last) begin
      state_next = '0;
    end else begin
      state_next.bytes_pending = pend_new;
      state_next.accumulator   = acc_new;
      state_next.units_done    = done_new;
      state_next.stopped       = stop_new;
    end
  end

endmodule

// ===== tb/tb.sv =====
// testbench for the utf-8 to utf-16 decoder: randomized byte streams checked against a predictor
`timescale 1ns / 100ps

module tb;
  import u8u16_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = RegCountOnly;
  logic [UnitW-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;

  utf8_to_utf16_decoder_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // bytes waiting to be offered, code unit results waiting to be seen
  in_item_t  byte_q[$];
  out_item_t unit_q[$];

  int err_cnt = 0;
  int bytes_queued = 0;
  int bytes_done = 0;
  int strings_queued = 0;
  int results_seen = 0;
  int units_seen = 0;
  logic byte_taken = 1'b0;
  logic no_gaps = 1'b0;
  logic hold_req = 1'b0;

  // receiver hold-off bookkeeping
  int   hold_left = 0;
  logic hold_done = 1'b0;

  // decoder state and register copies mirrored by the predictor
  logic [1:0]       pend = '0;
  logic [UnitW-1:0] acc = '0;
  logic [UnitW-1:0] units_done = '0;
  logic             halted = 1'b0;
  logic             mode_count = 1'b0;
  logic [UnitW-1:0] unit_limit = LimitReset;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("timeout after 5 ms");
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [UnitW-1:0] got,
                                 input logic [UnitW-1:0] want);
    begin
      if (err_cnt < 25)
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
      err_cnt++;
    end
  endtask

  // advance the decode state by one byte and queue the result it causes
  task automatic decode_byte(input in_item_t it);
    logic have, bad, emit;
    logic [UnitW-1:0] cu;
    out_item_t r;
    begin
      have = 1'b0;
      bad = 1'b0;
      emit = 1'b0;
      cu = '0;
      if (pend != 0) begin
        acc = {acc[UnitW-7:0], it.in_byte[5:0]};
        pend = pend - 1'b1;
        if (pend == 0) begin
          have = 1'b1;
          cu = acc;
        end
      end else if (it.in_byte <= AsciiMax) begin
        have = 1'b1;
        cu = {8'h00, it.in_byte};
      end else if (it.in_byte >= Lead2Min && it.in_byte <= Lead2Max) begin
        acc = {11'b0, it.in_byte[4:0]};
        pend = 2'd1;
      end else if (it.in_byte >= Lead3Min && it.in_byte <= Lead3Max) begin
        acc = {12'b0, it.in_byte[3:0]};
        pend = 2'd2;
      end else begin
        have = 1'b1;
        bad = 1'b1;
        cu = Replacement;
      end

      if (have) begin
        if (mode_count) begin
          if (units_done != UnitMax) units_done = units_done + 1'b1;
        end else if (!halted && units_done < unit_limit) begin
          units_done = units_done + 1'b1;
          emit = 1'b1;
        end else begin
          halted = 1'b1;
        end
      end

      if (emit || it.in_last) begin
        r.code_unit  = emit ? cu : '0;
        r.unit_valid = emit;
        r.bad_lead   = emit && bad;
        r.unit_count = units_done;
        r.truncated  = halted;
        r.out_last   = it.in_last;
        unit_q.push_back(r);
      end

      // string closed: back to a clean state
      if (it.in_last) begin
        pend = '0;
        acc = '0;
        units_done = '0;
        halted = 1'b0;
      end
    end
  endtask

  // input driver: offers queued bytes, idling at random
  always @(negedge clk) begin
    logic nxt_valid;
    in_item_t nxt_item;
    nxt_valid = in_valid;
    nxt_item = in_item;
    if (byte_taken) begin
      byte_taken = 1'b0;
      nxt_valid = 1'b0;
    end
    if (!rst && !nxt_valid && byte_q.size() > 0 &&
        (no_gaps || $urandom_range(99) >= 15)) begin
      nxt_item = byte_q.pop_front();
      nxt_valid = 1'b1;
    end
    in_valid <= nxt_valid;
    in_item <= nxt_item;
  end

  // result receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    logic rdy;
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left = 150;
      hold_done = 1'b1;
      rdy = 1'b0;
    end else if (no_gaps) begin
      rdy = 1'b1;
    end else begin
      rdy = ($urandom_range(99) >= 15);
    end
    out_ready <= rdy;
  end

  // monitor: predict on each byte transfer, check each result transfer
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        decode_byte(in_item);
        bytes_done++;
        byte_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_item.unit_valid) units_seen++;
        if (unit_q.size() == 0) begin
          report_mismatch("result with nothing expected", out_item.code_unit, '0);
        end else begin
          want = unit_q.pop_front();
          if (out_item.code_unit !== want.code_unit)
            report_mismatch("code_unit", out_item.code_unit, want.code_unit);
          if (out_item.unit_valid !== want.unit_valid)
            report_mismatch("unit_valid", out_item.unit_valid, want.unit_valid);
          if (out_item.bad_lead !== want.bad_lead)
            report_mismatch("bad_lead", out_item.bad_lead, want.bad_lead);
          if (out_item.unit_count !== want.unit_count)
            report_mismatch("unit_count", out_item.unit_count, want.unit_count);
          if (out_item.truncated !== want.truncated)
            report_mismatch("truncated", out_item.truncated, want.truncated);
          if (out_item.out_last !== want.out_last)
            report_mismatch("out_last", out_item.out_last, want.out_last);
        end
      end
    end
  end

  task automatic push_byte(input logic [ByteW-1:0] b, input logic last);
    in_item_t it;
    begin
      it.in_byte = b;
      it.in_last = last;
      byte_q.push_back(it);
      bytes_queued++;
      if (last) strings_queued++;
    end
  endtask

  function automatic logic [ByteW-1:0] cont_byte();
    if ($urandom_range(99) < 90) return 8'h80 | ByteW'($urandom_range(63));
    return ByteW'($urandom_range(255));
  endfunction

  // one string of mostly well-formed sequences with some noise
  task automatic push_random_string(output int n);
    logic [ByteW-1:0] seq_bytes[$];
    int n_seq, r;
    begin
      n_seq = $urandom_range(1, 10);
      for (int s = 0; s < n_seq; s++) begin
        r = $urandom_range(99);
        if (r < 45) begin
          seq_bytes.push_back(ByteW'($urandom_range(127)));
        end else if (r < 65) begin
          seq_bytes.push_back(Lead2Min | ByteW'($urandom_range(31)));
          seq_bytes.push_back(cont_byte());
        end else if (r < 85) begin
          seq_bytes.push_back(Lead3Min | ByteW'($urandom_range(15)));
          seq_bytes.push_back(cont_byte());
          seq_bytes.push_back(cont_byte());
        end else begin
          seq_bytes.push_back(ByteW'($urandom_range(255)));
        end
      end
      // sometimes cut the tail so the string can end inside a sequence
      if (seq_bytes.size() > 1 && $urandom_range(99) < 15) void'(seq_bytes.pop_back());
      n = seq_bytes.size();
      foreach (seq_bytes[i]) push_byte(seq_bytes[i], i == n - 1);
    end
  endtask

  task automatic push_random_bytes(input int target);
    int sent, n;
    begin
      sent = 0;
      while (sent < target) begin
        push_random_string(n);
        sent += n;
      end
    end
  endtask

  // a long run of ascii bytes closed by a last byte
  task automatic push_ascii_run(input int n);
    begin
      for (int i = 0; i < n; i++)
        push_byte(ByteW'($urandom_range(127)), i == n - 1);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [UnitW-1:0] val);
    begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      if (idx == RegCountOnly) mode_count = val[0];
      else unit_limit = val;
      @(negedge clk);
      cfg_we <= 1'b0;
    end
  endtask

  // wait until every byte is taken and every result seen, then let the pipe settle
  task automatic wait_drained();
    begin
      while (bytes_done != bytes_queued || unit_q.size() != 0) @(negedge clk);
      repeat (4) @(negedge clk);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: field extremes, all lead classes, unchecked following bytes, bad leads
    push_byte(8'h41, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hC0, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hDF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hE0, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hE1, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'hFF, 1'b1);
    // strings that end inside a sequence
    push_byte(8'hE2, 1'b0);
    push_byte(8'h82, 1'b1);
    push_byte(8'hC8, 1'b1);
    push_random_bytes(150);
    wait_drained();

    // limit of zero: nothing emitted
    write_reg(RegCountOnly, 16'd0);
    write_reg(RegOutLimit, 16'd0);
    push_random_bytes(80);
    wait_drained();

    // small limit, with a long receiver hold-off while bytes keep coming
    write_reg(RegOutLimit, 16'd3);
    push_random_bytes(150);
    hold_req = 1'b1;
    wait_drained();

    // count-only mode ignores the limit
    write_reg(RegCountOnly, 16'd1);
    write_reg(RegOutLimit, 16'd2);
    push_random_bytes(100);
    wait_drained();

    write_reg(RegCountOnly, 16'd0);
    write_reg(RegOutLimit, 16'd1);
    push_random_bytes(80);
    wait_drained();

    // long runs with no idling in both modes, the second under the largest limit
    no_gaps = 1'b1;
    write_reg(RegCountOnly, 16'd1);
    push_ascii_run(100);
    wait_drained();
    write_reg(RegCountOnly, 16'd0);
    write_reg(RegOutLimit, LimitReset);
    push_ascii_run(100);
    wait_drained();
    no_gaps = 1'b0;

    // random limits to finish
    write_reg(RegOutLimit, 16'($urandom_range(1, 8)));
    push_random_bytes(60);
    wait_drained();
    write_reg(RegCountOnly, 16'd1);
    push_random_bytes(60);
    wait_drained();

    repeat (10) @(negedge clk);
    $display("run covered %0d bytes in %0d strings, %0d results checked, %0d units emitted",
             bytes_done, strings_queued, results_seen, units_seen);
    $display("limits from 0 to 65535, count-only mode and a long output hold-off exercised");
    if (err_cnt == 0 && unit_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
